>>> sv/mma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants for the MIDI message assembler.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int SYSEX_CAPACITY_DEF = 16;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_MESSAGE   = 2'd0,
        KIND_REALTIME  = 2'd1,
        KIND_SYSEX_BYTE = 2'd2,
        KIND_SYSEX_END = 2'd3
    } t_kind;

    localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
    localparam logic [7:0] BYTE_SYSEX_START  = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_END    = 8'hF7;
    localparam logic [3:0] HI_PROGRAM        = 4'hC;
    localparam logic [3:0] HI_PRESSURE       = 4'hD;
    localparam logic [7:0] NO_STATUS         = 8'h00;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  status_byte;
        logic [4:0]  channel_number;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [31:0] message_time;
        logic [4:0]  sysex_position;
        logic        sysex_overflowed;
        logic [31:0] session_begin_time;
    } t_result;

    // Channel number shown for a status byte: low nibble plus one
    function automatic logic [4:0] chan_of(input logic [7:0] status);
        chan_of = {1'b0, status[3:0]} + 5'd1;
    endfunction

endpackage

>>> sv/midi_message_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_message_assembler
// Assembles timestamped MIDI bytes into messages with running status.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  ----------------------------------
//  input     in         i_valid / o_stall   i_cmd, i_byte_value, i_arrival_time
//  result    out        o_valid / i_stall   o_kind .. o_session_begin_time
//
//  One word is taken every cycle while o_stall is low; its result (if any) is
//  registered into the output register, or into the skid register if the output
//  is held. All assembly state updates in the accepting cycle, so back-to-back
//  words see each other's effect with no bubble. A two-entry output (main register
//  plus skid register) decouples the sides: o_stall rises only when the skid
//  register is occupied, and is registered. Reset (synchronous, active low)
//  clears all assembly and session state and empties both output registers.
// ----------------------------------------------------------------------------
module midi_message_assembler #(
    parameter int SYSEX_CAPACITY = mma_pkg::SYSEX_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_byte_value,
    input  logic [31:0] i_arrival_time,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_status_byte,
    output logic [4:0]  o_channel_number,
    output logic [6:0]  o_first_data,
    output logic [6:0]  o_second_data,
    output logic [31:0] o_message_time,
    output logic [4:0]  o_sysex_position,
    output logic        o_sysex_overflowed,
    output logic [31:0] o_session_begin_time
);
    import mma_pkg::*;

    // Sysex counter must hold the capacity itself
    localparam int CNT_W = $clog2(SYSEX_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(SYSEX_CAPACITY);

    // Assembly state
    logic [7:0]       r_running, n_running;
    logic             r_data_count, n_data_count;
    logic [6:0]       r_held, n_held;
    logic [31:0]      r_status_time, n_status_time;
    logic             r_in_excl, n_in_excl;
    logic [CNT_W-1:0] r_excl_count, n_excl_count;
    logic             r_excl_ovf, n_excl_ovf;
    logic             r_session_active, n_session_active;
    logic [31:0]      r_session_stamp, n_session_stamp;

    // Output registers
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic    in_acc, out_take, res_valid;
    t_result res;
    logic [CNT_W+4:0] count_ext;
    logic             one_byte;

    assign in_acc    = i_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_stall;
    assign count_ext = (CNT_W+5)'(r_excl_count);
    assign one_byte  = (r_running[7:4] == HI_PROGRAM) || (r_running[7:4] == HI_PRESSURE);

    // Next state and result for the word on the input
    always_comb begin
        n_running        = r_running;
        n_data_count     = r_data_count;
        n_held           = r_held;
        n_status_time    = r_status_time;
        n_in_excl        = r_in_excl;
        n_excl_count     = r_excl_count;
        n_excl_ovf       = r_excl_ovf;
        n_session_active = r_session_active;
        n_session_stamp  = r_session_stamp;
        res_valid        = 1'b0;
        res              = '0;
        res.session_begin_time = r_session_stamp;

        if (in_acc) begin
            if (i_cmd) begin
                // end the session, keep everything else
                n_session_active = 1'b0;
            end else if (i_byte_value >= BYTE_REALTIME_MIN) begin
                // real-time: pass straight through
                res_valid          = 1'b1;
                res.kind           = KIND_REALTIME;
                res.status_byte    = i_byte_value;
                res.channel_number = chan_of(i_byte_value);
                res.message_time   = i_arrival_time;
            end else if (i_byte_value[7]) begin
                // any other status: note its time, open a session if needed
                n_status_time = i_arrival_time;
                n_data_count  = 1'b0;
                if (!r_session_active) begin
                    n_session_active = 1'b1;
                    n_session_stamp  = i_arrival_time;
                end
                if (i_byte_value == BYTE_SYSEX_START) begin
                    n_running    = NO_STATUS;
                    n_in_excl    = 1'b1;
                    n_excl_count = '0;
                    n_excl_ovf   = 1'b0;
                end else if (i_byte_value == BYTE_SYSEX_END) begin
                    n_running = NO_STATUS;
                    n_in_excl = 1'b0;
                    if (r_in_excl) begin
                        res_valid              = 1'b1;
                        res.kind               = KIND_SYSEX_END;
                        res.status_byte        = BYTE_SYSEX_END;
                        res.channel_number     = chan_of(BYTE_SYSEX_END);
                        res.message_time       = r_status_time;
                        res.sysex_position     = count_ext[4:0];
                        res.sysex_overflowed   = r_excl_ovf;
                        res.session_begin_time = n_session_stamp;
                    end
                end else begin
                    // abandon any sysex, take the new running status
                    n_in_excl = 1'b0;
                    n_running = i_byte_value;
                end
            end else if (r_in_excl) begin
                // sysex data: report while room, else flag the drop
                if (r_excl_count < CAP) begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_SYSEX_BYTE;
                    res.status_byte    = BYTE_SYSEX_START;
                    res.channel_number = chan_of(BYTE_SYSEX_START);
                    res.first_data     = i_byte_value[6:0];
                    res.message_time   = r_status_time;
                    res.sysex_position = count_ext[4:0];
                    n_excl_count       = r_excl_count + CNT_W'(1);
                end else begin
                    n_excl_ovf = 1'b1;
                end
            end else if (r_running != NO_STATUS) begin
                res.kind           = KIND_MESSAGE;
                res.status_byte    = r_running;
                res.channel_number = chan_of(r_running);
                res.message_time   = r_status_time;
                if (one_byte) begin
                    n_data_count   = 1'b0;
                    res_valid      = 1'b1;
                    res.first_data = i_byte_value[6:0];
                end else if (!r_data_count) begin
                    // hold the first data byte until its partner arrives
                    n_held       = i_byte_value[6:0];
                    n_data_count = 1'b1;
                end else begin
                    n_data_count    = 1'b0;
                    res_valid       = 1'b1;
                    res.first_data  = r_held;
                    res.second_data = i_byte_value[6:0];
                end
            end
        end
    end

    // Assembly state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running        <= NO_STATUS;
            r_data_count     <= 1'b0;
            r_held           <= '0;
            r_status_time    <= '0;
            r_in_excl        <= 1'b0;
            r_excl_count     <= '0;
            r_excl_ovf       <= 1'b0;
            r_session_active <= 1'b0;
            r_session_stamp  <= '0;
        end else begin
            r_running        <= n_running;
            r_data_count     <= n_data_count;
            r_held           <= n_held;
            r_status_time    <= n_status_time;
            r_in_excl        <= n_in_excl;
            r_excl_count     <= n_excl_count;
            r_excl_ovf       <= n_excl_ovf;
            r_session_active <= n_session_active;
            r_session_stamp  <= n_session_stamp;
        end
    end

    // Output and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no new word while skid is full: drain it into the output
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_stall              = r_skid_valid;
    assign o_valid              = r_out_valid;
    assign o_kind               = r_out.kind;
    assign o_status_byte        = r_out.status_byte;
    assign o_channel_number     = r_out.channel_number;
    assign o_first_data         = r_out.first_data;
    assign o_second_data        = r_out.second_data;
    assign o_message_time       = r_out.message_time;
    assign o_sysex_position     = r_out.sysex_position;
    assign o_sysex_overflowed   = r_out.sysex_overflowed;
    assign o_session_begin_time = r_out.session_begin_time;

endmodule
